// ===== rtl/text_console_cursor_engine_top_macros.svh =====
// Assertion helpers for the console checker.
// Each macro expects a signal named clk in the scope of use; TCCE_ASSERT_NEXT also expects rst_n.
`ifndef TEXT_CONSOLE_CURSOR_ENGINE_TOP_MACROS_SVH
`define TEXT_CONSOLE_CURSOR_ENGINE_TOP_MACROS_SVH

// Next-cycle implication, switched off while reset is held.
`define TCCE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("console checker: property violated");

// Next-cycle implication that also holds across reset.
`define TCCE_ASSERT_NEXT_ALWAYS(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("console checker: property violated");

`endif

// ===== rtl/tcce_pkg.sv =====
package tcce_pkg;

  localparam int OPCODE_W = 2;
  localparam int CHAR_W   = 8;
  localparam int INDEX_W  = 12;
  localparam int OFFSET_W = 12;
  localparam int CELL_W   = 16;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 4;

  localparam logic [OPCODE_W-1:0] OP_PUT   = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_READ  = 2'd2;

  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;

  localparam logic [1:0] REG_COLUMNS   = 2'd0;
  localparam logic [1:0] REG_ROWS      = 2'd1;
  localparam logic [1:0] REG_ATTRIBUTE = 2'd2;

  localparam logic [7:0] RESET_COLUMNS   = 8'd80;
  localparam logic [5:0] RESET_ROWS      = 6'd25;
  localparam logic [7:0] RESET_ATTRIBUTE = 8'd79;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_SCROLL,
    ST_CLEAR,
    ST_RESP
  } tcce_state_t;

endpackage

// ===== rtl/tcce_if.sv =====
interface tcce_in_if;
  logic                          valid;
  logic                          ready;
  logic [tcce_pkg::OPCODE_W-1:0] opcode;
  logic [tcce_pkg::CHAR_W-1:0]   char_code;
  logic [tcce_pkg::INDEX_W-1:0]  cell_index;

  modport source (output valid, opcode, char_code, cell_index, input ready);
  modport sink   (input valid, opcode, char_code, cell_index, output ready);
endinterface

interface tcce_out_if;
  logic                          valid;
  logic                          ready;
  logic [tcce_pkg::OFFSET_W-1:0] cursor_offset;
  logic [tcce_pkg::CELL_W-1:0]   cell_value;

  modport source (output valid, cursor_offset, cell_value, input ready);
  modport sink   (input valid, cursor_offset, cell_value, output ready);
endinterface

// ===== rtl/text_console_cursor_engine_top.sv =====
// Channel   Direction  Role
// in_chan   sink       commands: put character, clear screen, read cell
// out_chan  source     one result per command: cursor offset and cell value
// cfg_*     APB slave  columns, rows and attribute registers
//
// A plain character, control character or cell read goes from acceptance
// through execute, then result, to a valid result; a new command is taken
// once the result is in the output register. Scrolling and clearing each add
// a pass over the columns*rows cells in use, one cell per cycle through the
// single write port of the cell memory. After reset the block sweeps all
// MAX_COLUMNS*MAX_ROWS cells to blank, one per cycle, with in_ready low; the
// configuration port works during that sweep. A stalled result holds in the
// output register while the next command is already accepted.
module text_console_cursor_engine_top #(
  parameter int MAX_COLUMNS = 128,
  parameter int MAX_ROWS    = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  tcce_in_if.sink                           in_chan,
  tcce_out_if.source                        out_chan,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [tcce_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [tcce_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [tcce_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                              cfg_pready
);

  // Geometry widths. CW holds a column count up to MAX_COLUMNS, CIW a column
  // index; RW and RIW likewise for rows.
  localparam int CELL_COUNT = MAX_COLUMNS * MAX_ROWS;
  localparam int AW   = $clog2(CELL_COUNT);
  localparam int CNTW = $clog2(CELL_COUNT + 1);
  localparam int CW   = $clog2(MAX_COLUMNS + 1);
  localparam int CIW  = $clog2(MAX_COLUMNS);
  localparam int RW   = $clog2(MAX_ROWS + 1);
  localparam int RIW  = $clog2(MAX_ROWS);
  localparam int LW   = RIW + CW + 1;

  localparam logic [tcce_pkg::CELL_W-1:0] RESET_BLANK =
    {tcce_pkg::RESET_ATTRIBUTE, tcce_pkg::CHAR_SPACE};

  // Configuration registers.
  logic [7:0] columns_r;
  logic [5:0] rows_r;
  logic [7:0] attr_r;
  logic       cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      columns_r <= tcce_pkg::RESET_COLUMNS;
      rows_r    <= tcce_pkg::RESET_ROWS;
      attr_r    <= tcce_pkg::RESET_ATTRIBUTE;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[3:2])
        tcce_pkg::REG_COLUMNS:   columns_r <= cfg_pwdata[7:0];
        tcce_pkg::REG_ROWS:      rows_r    <= cfg_pwdata[5:0];
        tcce_pkg::REG_ATTRIBUTE: attr_r    <= cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      tcce_pkg::REG_COLUMNS:   cfg_prdata = {24'd0, columns_r};
      tcce_pkg::REG_ROWS:      cfg_prdata = {26'd0, rows_r};
      tcce_pkg::REG_ATTRIBUTE: cfg_prdata = {24'd0, attr_r};
      default:                 cfg_prdata = '0;
    endcase
  end

  // Effective geometry: zero becomes one, oversize is limited to the maximum.
  // The counts and both area products are registered here, so every later
  // stage sees a register write only once it has passed this register too.
  logic [CW-1:0]   w_c;
  logic [RW-1:0]   h_c;
  logic [CW-1:0]   w_r;
  logic [RW-1:0]   h_r;
  logic [CNTW-1:0] area_r;
  logic [CNTW-1:0] last_r;

  always_comb begin
    if (columns_r == 8'd0) begin
      w_c = CW'(1);
    end else if (32'(columns_r) > MAX_COLUMNS) begin
      w_c = CW'(MAX_COLUMNS);
    end else begin
      w_c = CW'(columns_r);
    end
    if (rows_r == 6'd0) begin
      h_c = RW'(1);
    end else if (32'(rows_r) > MAX_ROWS) begin
      h_c = RW'(MAX_ROWS);
    end else begin
      h_c = RW'(rows_r);
    end
  end

  always_ff @(posedge clk) begin
    w_r    <= w_c;
    h_r    <= h_c;
    area_r <= CNTW'(w_c) * CNTW'(h_c);
    last_r <= CNTW'(w_c) * CNTW'(h_c - RW'(1));
  end

  // Cell memory: one write port, one registered read port.
  logic [tcce_pkg::CELL_W-1:0] mem [CELL_COUNT];
  logic                        wr_en;
  logic [AW-1:0]               wr_addr;
  logic [tcce_pkg::CELL_W-1:0] wr_data;
  logic                        rd_en;
  logic [AW-1:0]               rd_addr;
  logic [tcce_pkg::CELL_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Control and command registers.
  tcce_pkg::tcce_state_t state_r, state_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic [CIW-1:0]  col_r, col_nxt;
  logic [RIW-1:0]  row_r, row_nxt;
  logic            pend_r, pend_nxt;
  logic [AW-1:0]   pend_addr_r, pend_addr_nxt;
  logic            pend_blank_r, pend_blank_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [tcce_pkg::OFFSET_W-1:0] out_offset_r, out_offset_nxt;
  logic [tcce_pkg::CELL_W-1:0]   out_cell_r, out_cell_nxt;
  logic [tcce_pkg::OPCODE_W-1:0] op_r, op_nxt;
  logic [tcce_pkg::CHAR_W-1:0]   ch_r, ch_nxt;
  logic [AW-1:0]   idx_r, idx_nxt;
  logic            oob_r, oob_nxt;

  // Cursor clamped to the geometry in use, and the derived positions.
  logic [CIW-1:0] col_c;
  logic [RIW-1:0] row_c;
  logic [CW-1:0]  col_inc;
  logic [RW-1:0]  row_inc;
  logic [LW-1:0]  lin_c;
  logic [LW-1:0]  offset_c;
  logic [tcce_pkg::CELL_W-1:0] blank;
  logic           in_accept;

  assign col_c    = (CW'(col_r) >= w_r) ? CIW'(w_r - CW'(1)) : col_r;
  assign row_c    = (RW'(row_r) >= h_r) ? RIW'(h_r - RW'(1)) : row_r;
  assign col_inc  = CW'(col_c) + CW'(1);
  assign row_inc  = RW'(row_c) + RW'(1);
  assign lin_c    = LW'(row_c) * LW'(w_r) + LW'(col_c);
  assign offset_c = LW'(row_r) * LW'(w_r) + LW'(col_r);
  assign blank    = {attr_r, tcce_pkg::CHAR_SPACE};

  assign in_chan.ready          = (state_r == tcce_pkg::ST_IDLE);
  assign in_accept              = in_chan.valid && in_chan.ready;
  assign out_chan.valid         = out_valid_r;
  assign out_chan.cursor_offset = out_offset_r;
  assign out_chan.cell_value    = out_cell_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tcce_pkg::ST_INIT;
      cnt_r       <= '0;
      col_r       <= '0;
      row_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_addr_r  <= pend_addr_nxt;
    pend_blank_r <= pend_blank_nxt;
    out_offset_r <= out_offset_nxt;
    out_cell_r   <= out_cell_nxt;
    op_r         <= op_nxt;
    ch_r         <= ch_nxt;
    idx_r        <= idx_nxt;
    oob_r        <= oob_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    col_nxt        = col_r;
    row_nxt        = row_r;
    pend_nxt       = 1'b0;
    pend_addr_nxt  = pend_addr_r;
    pend_blank_nxt = pend_blank_r;
    out_valid_nxt  = out_valid_r && !out_chan.ready;
    out_offset_nxt = out_offset_r;
    out_cell_nxt   = out_cell_r;
    op_nxt         = op_r;
    ch_nxt         = ch_r;
    idx_nxt        = idx_r;
    oob_nxt        = oob_r;
    // By default the write port retires a pending scroll write, whose data
    // is either the row below (just read) or a blank.
    wr_en          = pend_r;
    wr_addr        = pend_addr_r;
    wr_data        = pend_blank_r ? blank : rd_data_r;
    rd_en          = 1'b0;
    rd_addr        = idx_r;

    unique case (state_r)
      tcce_pkg::ST_INIT: begin
        // Power-up sweep that blanks every cell with the reset attribute.
        wr_en   = 1'b1;
        wr_addr = AW'(cnt_r);
        wr_data = RESET_BLANK;
        if (cnt_r == CNTW'(CELL_COUNT - 1)) begin
          cnt_nxt   = '0;
          state_nxt = tcce_pkg::ST_IDLE;
        end else begin
          cnt_nxt = cnt_r + CNTW'(1);
        end
      end

      tcce_pkg::ST_IDLE: begin
        if (in_accept) begin
          op_nxt    = in_chan.opcode;
          ch_nxt    = in_chan.char_code;
          idx_nxt   = AW'(in_chan.cell_index);
          oob_nxt   = (32'(in_chan.cell_index) >= CELL_COUNT);
          state_nxt = tcce_pkg::ST_EXEC;
        end
      end

      tcce_pkg::ST_EXEC: begin
        // The clamp is kept even when the command leaves the cursor alone.
        col_nxt   = col_c;
        row_nxt   = row_c;
        cnt_nxt   = '0;
        state_nxt = tcce_pkg::ST_RESP;
        unique case (op_r)
          tcce_pkg::OP_PUT: begin
            priority if (ch_r == tcce_pkg::CHAR_CR) begin
              col_nxt = '0;
            end else if (ch_r == tcce_pkg::CHAR_LF) begin
              col_nxt = '0;
              if (row_inc >= h_r) begin
                state_nxt = tcce_pkg::ST_SCROLL;
              end else begin
                row_nxt = RIW'(row_inc);
              end
            end else if (ch_r == tcce_pkg::CHAR_TAB) begin
              col_nxt = col_c;
            end else if (ch_r == tcce_pkg::CHAR_BS) begin
              if (col_c != '0) begin
                col_nxt = col_c - CIW'(1);
              end
            end else begin
              wr_en   = 1'b1;
              wr_addr = AW'(lin_c);
              wr_data = {attr_r, ch_r};
              if (col_inc >= w_r) begin
                col_nxt = '0;
                if (row_inc >= h_r) begin
                  state_nxt = tcce_pkg::ST_SCROLL;
                end else begin
                  row_nxt = RIW'(row_inc);
                end
              end else begin
                col_nxt = CIW'(col_inc);
              end
            end
          end
          tcce_pkg::OP_CLEAR: begin
            col_nxt   = '0;
            row_nxt   = '0;
            state_nxt = tcce_pkg::ST_CLEAR;
          end
          tcce_pkg::OP_READ: begin
            rd_en   = 1'b1;
            rd_addr = idx_r;
          end
          default: ;
        endcase
      end

      tcce_pkg::ST_SCROLL: begin
        // Each cycle queues the write of the current cell for the next cycle and,
        // outside the last row, reads the cell one row below; the last row gets blanks.
        pend_nxt      = 1'b1;
        pend_addr_nxt = AW'(cnt_r);
        if (cnt_r < last_r) begin
          rd_en          = 1'b1;
          rd_addr        = AW'(cnt_r + CNTW'(w_r));
          pend_blank_nxt = 1'b0;
        end else begin
          pend_blank_nxt = 1'b1;
        end
        if (cnt_r == area_r - CNTW'(1)) begin
          state_nxt = tcce_pkg::ST_RESP;
        end else begin
          cnt_nxt = cnt_r + CNTW'(1);
        end
      end

      tcce_pkg::ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = AW'(cnt_r);
        wr_data = blank;
        if (cnt_r == area_r - CNTW'(1)) begin
          state_nxt = tcce_pkg::ST_RESP;
        end else begin
          cnt_nxt = cnt_r + CNTW'(1);
        end
      end

      tcce_pkg::ST_RESP: begin
        // Load the output register once the previous result has gone.
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt  = 1'b1;
          out_offset_nxt = tcce_pkg::OFFSET_W'(offset_c);
          out_cell_nxt   = (op_r == tcce_pkg::OP_READ && !oob_r) ? rd_data_r : '0;
          state_nxt      = tcce_pkg::ST_IDLE;
        end
      end

      default: state_nxt = tcce_pkg::ST_INIT;
    endcase
  end

endmodule

// ===== rtl/tcce_checker.sv =====
`include "text_console_cursor_engine_top_macros.svh"

module tcce_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [tcce_pkg::OFFSET_W-1:0] out_offset,
  input logic [tcce_pkg::CELL_W-1:0]   out_cell
);

  // A stalled result stays offered with the same payload.
  `TCCE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  `TCCE_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_offset) && $stable(out_cell))

  // Commands are worked one at a time.
  `TCCE_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready)

  // When no result is pending, none appears in the cycle right after a command is taken.
  `TCCE_ASSERT_NEXT(a_no_early_result, in_valid && in_ready && !out_valid, !out_valid)

  // The memory sweep after reset keeps the input closed.
  `TCCE_ASSERT_NEXT_ALWAYS(a_reset_closed, !rst_n, !in_ready)

endmodule

bind text_console_cursor_engine_top tcce_checker u_tcce_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_chan.valid),
  .in_ready   (in_chan.ready),
  .out_valid  (out_chan.valid),
  .out_ready  (out_chan.ready),
  .out_offset (out_chan.cursor_offset),
  .out_cell   (out_chan.cell_value)
);
